@@ sv/mmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared formats and constants for the escape-time iteration pipeline.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_WIDTH = 10;

    // Exact square / cross product and the sum of two of them
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = 2 * DATA_WIDTH + 1;

    localparam logic [ITER_WIDTH-1:0] ITER_RESET = ITER_WIDTH'(100);

    // 4.0 at 2*FRAC_BITS fraction bits
    localparam logic [SUM_WIDTH-1:0] ESCAPE_LIMIT =
        {{(SUM_WIDTH-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    typedef logic signed [DATA_WIDTH-1:0] fix_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;

    // Per-point context that rides along with z around the ring
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] c_real;
        logic signed [DATA_WIDTH-1:0] c_imag;
        logic [ITER_WIDTH-1:0]        cnt;
        logic                         escaped;
        logic                         no_iter;
    } ctx_t;

endpackage
`default_nettype wire

@@ sv/mmt_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_step
// Four-stage datapath for one z = z*z + c step plus the escape test.
// ----------------------------------------------------------------------------
module mmt_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire mmt_pkg::ctx_t in_ctx,
    input  wire mmt_pkg::fix_t in_z_re,
    input  wire mmt_pkg::fix_t in_z_im,
    output logic               s3_valid,
    output mmt_pkg::ctx_t      s3_ctx,
    output mmt_pkg::fix_t      s3_z_re,
    output mmt_pkg::fix_t      s3_z_im,
    output logic               s3_escape
);
    import mmt_pkg::*;

    // stage 0: operands
    logic  s0_valid_reg;
    ctx_t  s0_ctx_reg;
    fix_t  s0_re_reg, s0_im_reg;
    // stage 1: products of old z
    logic  s1_valid_reg;
    ctx_t  s1_ctx_reg;
    prod_t s1_rr_reg, s1_ii_reg, s1_ri_reg;
    // stage 2: new z
    logic  s2_valid_reg;
    ctx_t  s2_ctx_reg;
    fix_t  s2_re_reg, s2_im_reg;
    // stage 3: squares of new z
    logic  s3_valid_reg;
    ctx_t  s3_ctx_reg;
    fix_t  s3_re_reg, s3_im_reg;
    prod_t s3_rr_reg, s3_ii_reg;

    sum_t  diff, twice, re_shift, im_shift, mag;
    fix_t  re_next, im_next;

    always_comb
    begin
        diff     = SUM_WIDTH'(s1_rr_reg) - SUM_WIDTH'(s1_ii_reg);
        twice    = $signed({s1_ri_reg, 1'b0});
        re_shift = diff >>> FRAC_BITS;
        im_shift = twice >>> FRAC_BITS;
        re_next  = re_shift[DATA_WIDTH-1:0] + s1_ctx_reg.c_real;
        im_next  = im_shift[DATA_WIDTH-1:0] + s1_ctx_reg.c_imag;
        mag      = SUM_WIDTH'(s3_rr_reg) + SUM_WIDTH'(s3_ii_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctx_reg <= in_ctx;
            s0_re_reg  <= in_z_re;
            s0_im_reg  <= in_z_im;

            s1_ctx_reg <= s0_ctx_reg;
            s1_rr_reg  <= s0_re_reg * s0_re_reg;
            s1_ii_reg  <= s0_im_reg * s0_im_reg;
            s1_ri_reg  <= s0_re_reg * s0_im_reg;

            s2_ctx_reg <= s1_ctx_reg;
            s2_re_reg  <= re_next;
            s2_im_reg  <= im_next;

            s3_ctx_reg <= s2_ctx_reg;
            s3_re_reg  <= s2_re_reg;
            s3_im_reg  <= s2_im_reg;
            s3_rr_reg  <= s2_re_reg * s2_re_reg;
            s3_ii_reg  <= s2_im_reg * s2_im_reg;
        end
    end

    assign s3_valid  = s3_valid_reg;
    assign s3_ctx    = s3_ctx_reg;
    assign s3_z_re   = s3_re_reg;
    assign s3_z_im   = s3_im_reg;
    // magnitude squared is never negative, so an unsigned compare is exact
    assign s3_escape = $unsigned(mag) > ESCAPE_LIMIT;

endmodule
`default_nettype wire

@@ sv/mandelbrot_membership_test_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_membership_test_top
// Escape-time membership test for one complex point per transaction.
// ----------------------------------------------------------------------------
// Input channel: c_real / c_imag (signed Q4.28) with in_valid / in_stall.
// Output channel: inside_res with out_valid / out_stall; 1 means the point
// did not escape |z| > 2 within max_iterations steps.
// max_iterations is written through cfg_wr_en / cfg_wr_data; the user must
// do so only while idle, which the block itself does not enforce.
// The step z = z*z + c and the escape test form a four-stage ring
// (operands, products, new z, squares; the compare acts on the squares).
// Every point runs all max_iterations steps; an escape is latched and the
// point keeps circling, so points leave in arrival order. Up to four points
// share the ring. A new point enters only where a ring slot is empty or
// just finishing. If the output register is full and out_stall is high when
// a point finishes, the whole ring freezes; nothing is lost or repeated.
// Reset clears all valid bits and loads max_iterations with 100.
// ----------------------------------------------------------------------------
module mandelbrot_membership_test_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mmt_pkg::ITER_WIDTH-1:0]   cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [mmt_pkg::DATA_WIDTH-1:0] c_real,
    input  wire logic signed [mmt_pkg::DATA_WIDTH-1:0] c_imag,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  inside_res
);
    import mmt_pkg::*;

    logic [ITER_WIDTH-1:0] max_iter_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  inside_reg, inside_next;

    logic                  s3_valid, s3_escape;
    ctx_t                  s3_ctx;
    fix_t                  s3_z_re, s3_z_im;

    logic                  feed_valid;
    ctx_t                  feed_ctx;
    fix_t                  feed_re, feed_im;

    logic [ITER_WIDTH-1:0] cnt_inc;
    logic                  done, ring_go, slot_free, in_take, out_load;

    always_comb
    begin
        cnt_inc   = s3_ctx.cnt + 1'b1;
        // zero-iteration points take one lap but report inside
        done      = s3_ctx.no_iter || (cnt_inc == max_iter_reg);
        ring_go   = !(s3_valid && done && out_valid_reg && out_stall);
        slot_free = !s3_valid || done;
        in_stall  = !(ring_go && slot_free);
        in_take   = in_valid && !in_stall;
        out_load  = ring_go && s3_valid && done;

        feed_valid = 1'b0;
        feed_ctx   = s3_ctx;
        feed_re    = s3_z_re;
        feed_im    = s3_z_im;
        if (s3_valid && !done)
        begin
            feed_valid       = 1'b1;
            feed_ctx.cnt     = cnt_inc;
            feed_ctx.escaped = s3_ctx.escaped || s3_escape;
        end
        else if (in_take)
        begin
            feed_valid       = 1'b1;
            feed_ctx.c_real  = c_real;
            feed_ctx.c_imag  = c_imag;
            feed_ctx.cnt     = '0;
            feed_ctx.escaped = 1'b0;
            feed_ctx.no_iter = (max_iter_reg == '0);
            feed_re          = '0;
            feed_im          = '0;
        end

        inside_next    = s3_ctx.no_iter || !(s3_ctx.escaped || s3_escape);
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    mmt_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ring_go),
        .in_valid  (feed_valid),
        .in_ctx    (feed_ctx),
        .in_z_re   (feed_re),
        .in_z_im   (feed_im),
        .s3_valid  (s3_valid),
        .s3_ctx    (s3_ctx),
        .s3_z_re   (s3_z_re),
        .s3_z_im   (s3_z_im),
        .s3_escape (s3_escape)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= ITER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_iter_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule
`default_nettype wire
